FILE: hw/rtl/euler_to_basis_vectors_macros.svh
// Assertion macros for the Euler angle to basis vector block
`ifndef EULER_TO_BASIS_VECTORS_MACROS_SVH
`define EULER_TO_BASIS_VECTORS_MACROS_SVH
`ifndef SYNTHESIS
`define ETBV_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("etbv assertion failed");
`define ETBV_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("etbv assertion failed");
`else
`define ETBV_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define ETBV_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: hw/rtl/etbv_pkg.sv
// Shared types, constants and rounding functions for the basis vector block
`timescale 1ns / 1ps
package etbv_pkg;
   typedef logic signed [25:0] angle_type;
   typedef logic signed [26:0] zang_type;
   typedef logic signed [31:0] cxy_type;
   typedef logic signed [29:0] trig_type;
   typedef logic signed [30:0] prod_type;
   typedef logic signed [15:0] comp_type;

   localparam int TABLE_LEN = 24;
   localparam zang_type DEG360 = 27'sd23592960;
   localparam zang_type DEG180 = 27'sd11796480;
   localparam zang_type DEG90  = 27'sd5898240;
   localparam cxy_type  CORDIC_GAIN = 32'sd652032874;
   localparam logic signed [31:0] ONE_Q14 = 32'sd16384;

   localparam zang_type ATAN_TAB [TABLE_LEN] = '{
      27'sd2949120, 27'sd1740967, 27'sd919879, 27'sd466945, 27'sd234379, 27'sd117304,
      27'sd58666, 27'sd29335, 27'sd14668, 27'sd7334, 27'sd3667, 27'sd1833,
      27'sd917, 27'sd458, 27'sd229, 27'sd115, 27'sd57, 27'sd29,
      27'sd14, 27'sd7, 27'sd4, 27'sd2, 27'sd1, 27'sd0
   };

   function automatic prod_type mulq28(input prod_type a, input prod_type b);
      logic signed [61:0] p;
      p = 62'(a) * 62'(b);
      p = p + (62'sd1 <<< 27);
      return prod_type'(p >>> 28);
   endfunction

   function automatic comp_type to_q14(input logic signed [31:0] v);
      logic signed [31:0] r;
      r = (v + 32'sd8192) >>> 14;
      if (r > ONE_Q14) r = ONE_Q14;
      if (r < -ONE_Q14) r = -ONE_Q14;
      return comp_type'(r);
   endfunction
endpackage

FILE: hw/rtl/euler_to_basis_vectors.sv
// Top level: Euler angles in degrees to forward, right and up unit vectors
//
// Takes pitch, yaw and roll (signed Q9.16 degrees, any value reduced modulo
// 360) and returns the forward, right and up vectors as nine Q1.14 components
// saturated to plus or minus one. Three sine-cosine lanes run side by side,
// one per angle, each a fully pipelined CORDIC with one stage per step, and
// a three-stage product network merges them. One item is accepted per cycle
// unless a finished item waits; each lane runs min(TRIG_ITERATIONS, 24) steps.
// The whole pipeline holds while a finished item waits on the result side.
`timescale 1ns / 1ps
`include "euler_to_basis_vectors_macros.svh"
module euler_to_basis_vectors import etbv_pkg::*; #(
   parameter int TRIG_ITERATIONS = 16
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_ready,
   input  angle_type req_pitch_deg,
   input  angle_type req_yaw_deg,
   input  angle_type req_roll_deg,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output comp_type  rsp_forward_x,
   output comp_type  rsp_forward_y,
   output comp_type  rsp_forward_z,
   output comp_type  rsp_right_x,
   output comp_type  rsp_right_y,
   output comp_type  rsp_right_z,
   output comp_type  rsp_up_x,
   output comp_type  rsp_up_y,
   output comp_type  rsp_up_z
);
   localparam int STEPS = (TRIG_ITERATIONS < TABLE_LEN) ? TRIG_ITERATIONS : TABLE_LEN;
   localparam int LAT   = STEPS + 6;

   logic           adv;
   logic [LAT-1:0] valid_ff, valid_in;
   trig_type       sp, cp, sy, cy, sr, cr;
   logic           fz_ok, uz_ok;

   assign adv       = !valid_ff[LAT-1] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = valid_ff[LAT-1];
   assign valid_in  = {valid_ff[LAT-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   etbv_cordic #(.STEPS(STEPS)) u_pitch (
      .clock(clock), .en(adv), .ang(req_pitch_deg), .sin_q28(sp), .cos_q28(cp)
   );
   etbv_cordic #(.STEPS(STEPS)) u_yaw (
      .clock(clock), .en(adv), .ang(req_yaw_deg), .sin_q28(sy), .cos_q28(cy)
   );
   etbv_cordic #(.STEPS(STEPS)) u_roll (
      .clock(clock), .en(adv), .ang(req_roll_deg), .sin_q28(sr), .cos_q28(cr)
   );

   etbv_merge u_merge (
      .clock(clock), .en(adv),
      .sp(sp), .cp(cp), .sy(sy), .cy(cy), .sr(sr), .cr(cr),
      .forward_x(rsp_forward_x), .forward_y(rsp_forward_y), .forward_z(rsp_forward_z),
      .right_x(rsp_right_x), .right_y(rsp_right_y), .right_z(rsp_right_z),
      .up_x(rsp_up_x), .up_y(rsp_up_y), .up_z(rsp_up_z)
   );

   assign fz_ok = (rsp_forward_z <= 16'sd16384) && (rsp_forward_z >= -16'sd16384);
   assign uz_ok = (rsp_up_z <= 16'sd16384) && (rsp_up_z >= -16'sd16384);

   `ETBV_ASSERT_NEXT(a_hold_item, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `ETBV_ASSERT_NOW(a_fz_range, clock, reset, rsp_valid, fz_ok)
   `ETBV_ASSERT_NOW(a_uz_range, clock, reset, rsp_valid, uz_ok)
   `ETBV_ASSERT_NEXT(a_stall_freeze, clock, reset, rsp_valid && !rsp_ready, $stable(valid_ff))
endmodule

FILE: hw/rtl/etbv_cordic.sv
// Pipelined sine and cosine lane working in Q16 degrees
`timescale 1ns / 1ps
module etbv_cordic import etbv_pkg::*; #(
   parameter int STEPS = 16
) (
   input  logic      clock,
   input  logic      en,
   input  angle_type ang,
   output trig_type  sin_q28,
   output trig_type  cos_q28
);
   zang_type mod_in, mod_ff, fold_in;
   logic     flip_in;
   cxy_type  x_ff [STEPS+1];
   cxy_type  y_ff [STEPS+1];
   zang_type z_ff [STEPS+1];
   logic     f_ff [STEPS+1];
   cxy_type  xr, yr;
   trig_type sin_ff, cos_ff;

   always_comb begin
      mod_in = zang_type'(ang);
      if (mod_in >= DEG360) begin
         mod_in = mod_in - DEG360;
      end else if (mod_in <= -DEG360) begin
         mod_in = mod_in + DEG360;
      end
   end

   always_comb begin
      fold_in = mod_ff;
      flip_in = 1'b0;
      if (fold_in >= DEG180) begin
         fold_in = fold_in - DEG360;
      end else if (fold_in < -DEG180) begin
         fold_in = fold_in + DEG360;
      end
      if (fold_in > DEG90) begin
         fold_in = fold_in - DEG180;
         flip_in = 1'b1;
      end else if (fold_in < -DEG90) begin
         fold_in = fold_in + DEG180;
         flip_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mod_ff  <= mod_in;
         x_ff[0] <= CORDIC_GAIN;
         y_ff[0] <= '0;
         z_ff[0] <= fold_in;
         f_ff[0] <= flip_in;
      end
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      cxy_type  x_in, y_in;
      zang_type z_in;
      always_comb begin
         if (z_ff[i] >= 0) begin
            x_in = x_ff[i] - (y_ff[i] >>> i);
            y_in = y_ff[i] + (x_ff[i] >>> i);
            z_in = z_ff[i] - ATAN_TAB[i];
         end else begin
            x_in = x_ff[i] + (y_ff[i] >>> i);
            y_in = y_ff[i] - (x_ff[i] >>> i);
            z_in = z_ff[i] + ATAN_TAB[i];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i+1] <= x_in;
            y_ff[i+1] <= y_in;
            z_ff[i+1] <= z_in;
            f_ff[i+1] <= f_ff[i];
         end
      end
   end

   always_comb begin
      xr = (x_ff[STEPS] + 32'sd2) >>> 2;
      yr = (y_ff[STEPS] + 32'sd2) >>> 2;
      if (f_ff[STEPS]) begin
         xr = -xr;
         yr = -yr;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cos_ff <= trig_type'(xr);
         sin_ff <= trig_type'(yr);
      end
   end

   assign sin_q28 = sin_ff;
   assign cos_q28 = cos_ff;
endmodule

FILE: hw/rtl/etbv_merge.sv
// Product and sum stages that combine the three lanes into basis vectors
`timescale 1ns / 1ps
module etbv_merge import etbv_pkg::*; (
   input  logic     clock,
   input  logic     en,
   input  trig_type sp, cp, sy, cy, sr, cr,
   output comp_type forward_x, forward_y, forward_z,
   output comp_type right_x, right_y, right_z,
   output comp_type up_x, up_y, up_z
);
   prod_type srsp_ff, crsp_ff, cpcy_ff, cpsy_ff, srcp_ff, crcp_ff;
   prod_type crsy_ff, crcy_ff, srsy_ff, srcy_ff, sp1_ff;
   trig_type cy1_ff, sy1_ff;
   prod_type a_ff, b_ff, c_ff, d_ff;
   prod_type cpcy2_ff, cpsy2_ff, srcp2_ff, crcp2_ff, crsy2_ff, crcy2_ff;
   prod_type srsy2_ff, srcy2_ff, sp2_ff;
   comp_type fx_ff, fy_ff, fz_ff, rx_ff, ry_ff, rz_ff, ux_ff, uy_ff, uz_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         srsp_ff <= mulq28(prod_type'(sr), prod_type'(sp));
         crsp_ff <= mulq28(prod_type'(cr), prod_type'(sp));
         cpcy_ff <= mulq28(prod_type'(cp), prod_type'(cy));
         cpsy_ff <= mulq28(prod_type'(cp), prod_type'(sy));
         srcp_ff <= mulq28(prod_type'(sr), prod_type'(cp));
         crcp_ff <= mulq28(prod_type'(cr), prod_type'(cp));
         crsy_ff <= mulq28(prod_type'(cr), prod_type'(sy));
         crcy_ff <= mulq28(prod_type'(cr), prod_type'(cy));
         srsy_ff <= mulq28(prod_type'(sr), prod_type'(sy));
         srcy_ff <= mulq28(prod_type'(sr), prod_type'(cy));
         sp1_ff  <= prod_type'(sp);
         cy1_ff  <= cy;
         sy1_ff  <= sy;

         a_ff     <= mulq28(srsp_ff, prod_type'(cy1_ff));
         b_ff     <= mulq28(srsp_ff, prod_type'(sy1_ff));
         c_ff     <= mulq28(crsp_ff, prod_type'(cy1_ff));
         d_ff     <= mulq28(crsp_ff, prod_type'(sy1_ff));
         cpcy2_ff <= cpcy_ff;
         cpsy2_ff <= cpsy_ff;
         srcp2_ff <= srcp_ff;
         crcp2_ff <= crcp_ff;
         crsy2_ff <= crsy_ff;
         crcy2_ff <= crcy_ff;
         srsy2_ff <= srsy_ff;
         srcy2_ff <= srcy_ff;
         sp2_ff   <= sp1_ff;

         fx_ff <= to_q14(32'(cpcy2_ff));
         fy_ff <= to_q14(32'(cpsy2_ff));
         fz_ff <= to_q14(-32'(sp2_ff));
         rx_ff <= to_q14(32'(crsy2_ff) - 32'(a_ff));
         ry_ff <= to_q14(-32'(b_ff) - 32'(crcy2_ff));
         rz_ff <= to_q14(-32'(srcp2_ff));
         ux_ff <= to_q14(32'(c_ff) + 32'(srsy2_ff));
         uy_ff <= to_q14(32'(d_ff) - 32'(srcy2_ff));
         uz_ff <= to_q14(32'(crcp2_ff));
      end
   end

   assign forward_x = fx_ff;
   assign forward_y = fy_ff;
   assign forward_z = fz_ff;
   assign right_x   = rx_ff;
   assign right_y   = ry_ff;
   assign right_z   = rz_ff;
   assign up_x      = ux_ff;
   assign up_y      = uy_ff;
   assign up_z      = uz_ff;
endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the Euler angle to basis vector block
`timescale 1ns / 1ps
module testbench import etbv_pkg::*; ();

   typedef logic signed [8:0][15:0] basis_type;

   localparam int ITER = 16;
   localparam longint FULL_TURN = 23592960;
   localparam longint HALF_TURN = 11796480;
   localparam longint QUARTER = 5898240;
   localparam longint ATAN_DEG [24] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0
   };
   localparam string COMP_NAME [9] = '{
      "forward_x", "forward_y", "forward_z", "right_x", "right_y", "right_z",
      "up_x", "up_y", "up_z"
   };

   typedef struct {
      angle_type pitch;
      angle_type yaw;
      angle_type roll;
      bit        typed;
      basis_type vec;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   angle_type req_pitch_deg = '0;
   angle_type req_yaw_deg = '0;
   angle_type req_roll_deg = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   comp_type rsp_forward_x, rsp_forward_y, rsp_forward_z;
   comp_type rsp_right_x, rsp_right_y, rsp_right_z;
   comp_type rsp_up_x, rsp_up_y, rsp_up_z;

   basis_type    pending_basis [$];
   int           errors = 0;
   int           idle_pct = 11;
   stim_row_type directed [$];

   euler_to_basis_vectors #(.TRIG_ITERATIONS(ITER)) dut (.*);

   always #10 clock = ~clock;

   initial begin
      #5_000_000;
      $display("euler_to_basis_vectors: mismatch");
      $finish;
   end

   task automatic report(input string msg);
      $display("ERROR %0t: %s", $realtime, msg);
      errors++;
   endtask

   function automatic void sin_cos_deg(input longint ang, output longint s, output longint c);
      longint r, x, y, z, xs, ys;
      bit     flip;
      r = ang % FULL_TURN;
      flip = 1'b0;
      x = 652032874;
      y = 0;
      if (r >= HALF_TURN) r -= FULL_TURN;
      if (r < -HALF_TURN) r += FULL_TURN;
      if (r > QUARTER) begin
         r -= HALF_TURN;
         flip = 1'b1;
      end else if (r < -QUARTER) begin
         r += HALF_TURN;
         flip = 1'b1;
      end
      z = r;
      for (int i = 0; i < ITER && i < 24; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x -= ys;
            y += xs;
            z -= ATAN_DEG[i];
         end else begin
            x += ys;
            y -= xs;
            z += ATAN_DEG[i];
         end
      end
      x = (x + 2) >>> 2;
      y = (y + 2) >>> 2;
      s = flip ? -y : y;
      c = flip ? -x : x;
   endfunction

   function automatic longint mul28(input longint a, input longint b);
      return (a * b + (longint'(1) <<< 27)) >>> 28;
   endfunction

   function automatic logic signed [15:0] round_q14(input longint v);
      longint r;
      r = (v + 8192) >>> 14;
      if (r > 16384) r = 16384;
      if (r < -16384) r = -16384;
      return 16'(r);
   endfunction

   function automatic basis_type orient_basis(input angle_type p, input angle_type yw,
                                              input angle_type rl);
      longint sp, cp, sy, cy, sr, cr, srsp, crsp;
      basis_type b;
      sin_cos_deg(longint'(p), sp, cp);
      sin_cos_deg(longint'(yw), sy, cy);
      sin_cos_deg(longint'(rl), sr, cr);
      srsp = mul28(sr, sp);
      crsp = mul28(cr, sp);
      b[0] = round_q14(mul28(cp, cy));
      b[1] = round_q14(mul28(cp, sy));
      b[2] = round_q14(-sp);
      b[3] = round_q14(-mul28(srsp, cy) + mul28(cr, sy));
      b[4] = round_q14(-mul28(srsp, sy) - mul28(cr, cy));
      b[5] = round_q14(-mul28(sr, cp));
      b[6] = round_q14(mul28(crsp, cy) + mul28(sr, sy));
      b[7] = round_q14(mul28(crsp, sy) - mul28(sr, cy));
      b[8] = round_q14(mul28(cr, cp));
      return b;
   endfunction

   task automatic send_angles(input angle_type p, input angle_type yw, input angle_type rl);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pitch_deg <= p;
      req_yaw_deg <= yw;
      req_roll_deg <= rl;
      do @(posedge clock); while (!req_ready);
      pending_basis.push_back(orient_basis(p, yw, rl));
   endtask

   function automatic angle_type pick_angle();
      int unsigned k;
      k = $urandom_range(0, 99);
      if (k < 10) return angle_type'($urandom());
      if (k < 25) return angle_type'(longint'($urandom_range(0, 8)) * QUARTER / 2
                                     - FULL_TURN + $urandom_range(0, 4) - 2);
      return angle_type'(longint'($urandom_range(0, 2 * FULL_TURN)) - FULL_TURN);
   endfunction

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= idle_pct);
   end

   always @(posedge clock) begin
      basis_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_up_z, rsp_up_y, rsp_up_x, rsp_right_z, rsp_right_y, rsp_right_x,
                rsp_forward_z, rsp_forward_y, rsp_forward_x};
         if (pending_basis.size() == 0) begin
            report("result with nothing outstanding");
         end else begin
            want = pending_basis.pop_front();
            for (int i = 0; i < 9; i++)
               if (got[i] !== want[i])
                  report($sformatf("%s got %0d want %0d", COMP_NAME[i],
                                   $signed(got[i]), $signed(want[i])));
         end
      end
   end

   initial begin
      angle_type a [$];
      basis_type want;
      a = '{0, 5898240, -5898240, 11796480, -11796480, 23592960, -23592960,
            26'sh1FFFFFF, -26'sh2000000, 2949120, 17694720, 1, -1};
      directed.push_back('{0, 0, 0, 1'b1,
                           {16'sd16384, 16'sd0, 16'sd0, 16'sd0, -16'sd16384, 16'sd0,
                            16'sd0, 16'sd0, 16'sd16384}});
      foreach (a[i]) directed.push_back('{a[i], a[(i + 4) % 13], a[(i + 9) % 13], 1'b0, '0});
      directed.push_back('{5898240, 0, 0, 1'b0, '0});
      directed.push_back('{0, 5898240, 0, 1'b0, '0});
      directed.push_back('{0, 0, 5898240, 1'b0, '0});
      directed.push_back('{0, 0, -5898240, 1'b0, '0});
      directed.push_back('{2949120, 2949120, 2949120, 1'b0, '0});
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[i]) begin
         send_angles(directed[i].pitch, directed[i].yaw, directed[i].roll);
         if (directed[i].typed) begin
            want = pending_basis[$];
            for (int k = 0; k < 9; k++)
               if (want[k] !== directed[i].vec[k])
                  report($sformatf("row %0d %s predicted %0d typed %0d", i, COMP_NAME[k],
                                   $signed(want[k]), $signed(directed[i].vec[k])));
         end
      end
      for (int n = 0; n < 1850; n++) begin
         idle_pct = (n >= 600 && n < 900) ? 0 : 11;
         if (n == 1000) begin
            req_valid <= 1'b0;
            while (pending_basis.size() != 0) @(posedge clock);
         end
         send_angles(pick_angle(), pick_angle(), pick_angle());
      end
      req_valid <= 1'b0;
      idle_pct = 11;
      while (pending_basis.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (errors == 0)
         $display("euler_to_basis_vectors: match");
      else
         $display("euler_to_basis_vectors: mismatch");
      $finish;
   end
endmodule
